@@ hw/rtl/vdu_pkg.sv @@
// shared types, constants and helpers for the video dump unpacker
`timescale 1ns / 1ps
`default_nettype none

package vdu_pkg;

	// gearbox geometry
	localparam int WORD_BYTES  = 8;
	localparam int HOLD_MAX    = 4;
	localparam int MAX_PIX     = 4;
	localparam int BUF_BYTES   = HOLD_MAX + WORD_BYTES;
	localparam int BUF_W       = BUF_BYTES * 8;
	localparam int TOTAL_W     = $clog2(BUF_BYTES + 1);
	localparam int HOLD_CNT_W  = $clog2(HOLD_MAX + 1);
	localparam int NPIX_W      = $clog2(MAX_PIX + 1);
	localparam int PIX_IDX_W   = $clog2(MAX_PIX);
	localparam int QUEUE_DEPTH = 2;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_SPACE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEN_BIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_REVERSE = 2'd2;

	// bt.709 coefficients in q12
	localparam logic signed [23:0] K_Y  = 24'sd4768;
	localparam logic signed [23:0] K_VR = 24'sd7344;
	localparam logic signed [23:0] K_VG = 24'sd2187;
	localparam logic signed [23:0] K_UG = 24'sd872;
	localparam logic signed [23:0] K_UB = 24'sd8663;

	typedef enum logic [1:0] {
		MODE_RGB    = 2'd0,
		MODE_YUV422 = 2'd1,
		MODE_YUV444 = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  ten_bit;
		logic  byte_reverse;
	} cfg_t;

	typedef struct packed {
		logic [63:0] data_word;
		logic        last_word;
	} word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_t;

	// one word worth of gearbox bytes, ready for conversion
	typedef struct packed {
		logic [BUF_W-1:0]  bytes;
		logic [NPIX_W-1:0] npix;
		logic              last;
	} entry_t;

	// bytes taken by one pixel group
	function automatic logic [2:0] group_bytes(input cfg_t c);
		logic [2:0] g;
		if (c.mode == MODE_YUV422) begin
			g = c.ten_bit ? 3'd5 : 3'd4;
		end else begin
			g = c.ten_bit ? 3'd4 : 3'd3;
		end
		return g;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vdu_front.sv @@
// front end: byte gearbox, group count and hand-off into the queue
`timescale 1ns / 1ps
`default_nettype none

module vdu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  vdu_pkg::cfg_t   cfg,
	input  logic            cfg_clear,
	input  logic            word_valid,
	output logic            word_ready,
	input  vdu_pkg::word_t  word,
	input  logic            q_full,
	output logic            q_push,
	output vdu_pkg::entry_t q_data
);
	import vdu_pkg::*;

	logic [31:0]            held_q;
	logic [HOLD_CNT_W-1:0]  held_cnt_q;
	logic [BUF_W-1:0]       gbuf;
	logic [TOTAL_W-1:0]     total;
	logic [2:0]             grp;
	logic [NPIX_W-1:0]      max_groups;
	logic [NPIX_W-1:0]      groups;
	logic [NPIX_W-1:0]      npix;
	logic [TOTAL_W-1:0]     pos;
	logic [TOTAL_W-1:0]     left;
	logic [BUF_W-1:0]       rest;
	logic [HOLD_CNT_W-1:0]  held_next;
	logic                   accept;

	// leftover bytes first, then the bytes of the new word
	always_comb begin
		int src;
		logic [7:0] wbyte;
		gbuf = '0;
		for (int j = 0; j < HOLD_MAX; j++) begin
			if (j < int'(held_cnt_q)) begin
				gbuf[8*j +: 8] = held_q[8*j +: 8];
			end
		end
		for (int w = 0; w < WORD_BYTES; w++) begin
			src = cfg.byte_reverse ? (WORD_BYTES - 1 - w) : w;
			wbyte = '0;
			if (src < 8) begin
				wbyte = word.data_word[8*src +: 8];
			end
			gbuf[8*(int'(held_cnt_q) + w) +: 8] = wbyte;
		end
	end

	// how many whole groups fit, capped by the pixel limit
	always_comb begin
		total      = TOTAL_W'(held_cnt_q) + TOTAL_W'(WORD_BYTES);
		grp        = group_bytes(cfg);
		max_groups = (cfg.mode == MODE_YUV422) ? NPIX_W'(MAX_PIX / 2) : NPIX_W'(MAX_PIX);
		groups     = '0;
		pos        = '0;
		for (int j = 1; j <= MAX_PIX; j++) begin
			if (j <= int'(max_groups) && j * int'(grp) <= int'(total)) begin
				groups = NPIX_W'(j);
				pos    = TOTAL_W'(j * int'(grp));
			end
		end
		npix      = (cfg.mode == MODE_YUV422) ? (groups << 1) : groups;
		left      = total - pos;
		rest      = gbuf >> (8 * pos);
		held_next = (left > TOTAL_W'(HOLD_MAX)) ? HOLD_CNT_W'(HOLD_MAX) : HOLD_CNT_W'(left);
	end

	// handshake and queue hand-off
	assign word_ready  = !q_full;
	assign accept      = word_valid && word_ready;
	assign q_push      = accept && (groups != '0);
	assign q_data.bytes = gbuf;
	assign q_data.npix  = npix;
	assign q_data.last  = word.last_word;

	// gearbox state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= '0;
		end else if (cfg_clear) begin
			held_cnt_q <= '0;
		end else if (accept) begin
			held_q     <= rest[31:0];
			held_cnt_q <= word.last_word ? '0 : held_next;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/vdu_queue.sv @@
// short queue of gearbox entries between front and back
`timescale 1ns / 1ps
`default_nettype none

module vdu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vdu_pkg::entry_t push_data,
	input  logic            pop,
	output vdu_pkg::entry_t head,
	output logic            full,
	output logic            empty
);
	import vdu_pkg::*;

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/vdu_back.sv @@
// back end: pixel sequencer, sample unpack and bt.709 conversion pipeline
`timescale 1ns / 1ps
`default_nettype none

module vdu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  vdu_pkg::cfg_t   cfg,
	input  logic            q_empty,
	input  vdu_pkg::entry_t q_head,
	output logic            q_pop,
	output logic            pixel_valid,
	input  logic            pixel_ready,
	output vdu_pkg::pixel_t pixel
);
	import vdu_pkg::*;

	localparam int BASE_W = $clog2((MAX_PIX - 1) * 5 + 1);

	logic [PIX_IDX_W-1:0] px_q;
	logic                 adv;
	logic                 issue;
	logic                 final_px;
	logic [PIX_IDX_W-1:0] grp_idx;
	logic                 sub;
	logic [BASE_W-1:0]    base;
	logic [BUF_W+39:0]    win;
	logic [4:0][7:0]      gb;
	logic [7:0]           a;
	logic [7:0]           b;
	logic [7:0]           c;

	logic                 valid_s1;
	logic [7:0]           a_s1;
	logic [7:0]           b_s1;
	logic [7:0]           c_s1;
	logic                 yuv_s1;
	logic                 last_s1;

	logic signed [8:0]    y_off;
	logic signed [8:0]    u_off;
	logic signed [8:0]    v_off;

	logic                 valid_s2;
	logic [7:0]           a_s2;
	logic [7:0]           b_s2;
	logic [7:0]           c_s2;
	logic                 yuv_s2;
	logic                 last_s2;
	logic signed [23:0]   py_s2;
	logic signed [23:0]   pvr_s2;
	logic signed [23:0]   pvg_s2;
	logic signed [23:0]   pug_s2;
	logic signed [23:0]   pub_s2;

	logic signed [23:0]   sum_r;
	logic signed [23:0]   sum_g;
	logic signed [23:0]   sum_b;
	logic                 out_valid_q;
	pixel_t               pixel_q;

	// floor of q12 value, clamped to 0..255
	function automatic logic [7:0] sat8(input logic signed [23:0] s);
		logic [7:0] r;
		if (s < 0) begin
			r = 8'd0;
		end else if (s[22:20] != 3'd0) begin
			r = 8'd255;
		end else begin
			r = s[19:12];
		end
		return r;
	endfunction

	// whole pipeline moves unless the output beat is stuck
	assign adv      = !out_valid_q || pixel_ready;
	assign issue    = adv && !q_empty;
	assign final_px = ({1'b0, px_q} + 1'b1) == q_head.npix;
	assign q_pop    = issue && final_px;

	// pixel counter within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
		end else if (issue) begin
			px_q <= final_px ? '0 : px_q + 1'b1;
		end
	end

	// locate the group for this pixel
	always_comb begin
		if (cfg.mode == MODE_YUV422) begin
			grp_idx = px_q >> 1;
			sub     = px_q[0];
		end else begin
			grp_idx = px_q;
			sub     = 1'b0;
		end
		base = BASE_W'(grp_idx) * BASE_W'(group_bytes(cfg));
		win  = {40'b0, q_head.bytes} >> (8 * base);
		gb   = win[39:0];
	end

	// unpack samples: a/b/c are r/g/b or y/u/v
	always_comb begin
		unique case (cfg.mode)
			MODE_YUV422: begin
				if (cfg.ten_bit) begin
					a = sub ? {gb[2][3:0], gb[3][7:4]} : gb[0];
					b = {gb[1][5:0], gb[2][7:6]};
					c = {gb[3][1:0], gb[4][7:2]};
				end else begin
					a = sub ? gb[2] : gb[0];
					b = gb[1];
					c = gb[3];
				end
			end
			default: begin
				if (cfg.ten_bit) begin
					a = {gb[0][5:0], gb[1][7:6]};
					b = {gb[1][3:0], gb[2][7:4]};
					c = {gb[2][1:0], gb[3][7:2]};
				end else begin
					a = gb[0];
					b = gb[1];
					c = gb[2];
				end
			end
		endcase
	end

	// stage 1: selected samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= a;
			b_s1    <= b;
			c_s1    <= c;
			yuv_s1  <= (cfg.mode == MODE_YUV422) || (cfg.mode == MODE_YUV444);
			last_s1 <= q_head.last && final_px;
		end
	end

	// stage 2: coefficient products
	always_comb begin
		y_off = $signed({1'b0, a_s1}) - 9'sd16;
		u_off = $signed({1'b0, b_s1}) - 9'sd128;
		v_off = $signed({1'b0, c_s1}) - 9'sd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			yuv_s2  <= yuv_s1;
			last_s2 <= last_s1;
			py_s2   <= 24'(y_off) * K_Y;
			pvr_s2  <= 24'(v_off) * K_VR;
			pvg_s2  <= 24'(v_off) * K_VG;
			pug_s2  <= 24'(u_off) * K_UG;
			pub_s2  <= 24'(u_off) * K_UB;
		end
	end

	// sums and clamp into the output register
	always_comb begin
		sum_r = py_s2 + pvr_s2;
		sum_g = py_s2 - pvg_s2 - pug_s2;
		sum_b = py_s2 + pub_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q.red        <= yuv_s2 ? sat8(sum_r) : a_s2;
			pixel_q.green      <= yuv_s2 ? sat8(sum_g) : b_s2;
			pixel_q.blue       <= yuv_s2 ? sat8(sum_b) : c_s2;
			pixel_q.last_pixel <= last_s2;
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel       = pixel_q;

endmodule

`default_nettype wire

@@ hw/rtl/video_dump_unpack_to_rgb.sv @@
// top level: configuration registers, front gearbox, queue and pixel back end
//
// Input beats on word (valid/ready) carry one 64-bit dump word, first byte in
// bits 7:0, and a last_word flag. Output beats on pixel (valid/ready) carry one
// 8-bit rgb pixel; last_pixel marks the final pixel of a frame's last word.
// Configuration goes through cfg_we/cfg_index/cfg_data: 0 colour space, 1 ten
// bit, 2 byte reverse; each write to one of these empties the byte gearbox.
// Path: a word's entry is written into the queue, then each pixel passes the
// stage 1, stage 2 and output registers. Throughput: one pixel per cycle
// through the single conversion pipeline while the pixel receiver takes
// them; a pushed word yields one to four pixels, and words that complete no
// pixel group are not pushed into the queue. The front takes a word in every
// cycle that the two-entry queue has room.
// Reset: registers return to rgb eight-bit, no reversal; gearbox and queue
// are empty.
// When the pixel receiver stalls, the conversion pipeline freezes; the front
// keeps accepting words until the queue is full, then drops word_ready.
`timescale 1ns / 1ps
`default_nettype none

module video_dump_unpack_to_rgb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vdu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vdu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                word_valid,
	output logic                                word_ready,
	input  vdu_pkg::word_t                      word,
	output logic                                pixel_valid,
	input  logic                                pixel_ready,
	output vdu_pkg::pixel_t                     pixel
);
	import vdu_pkg::*;

	cfg_t   cfg_q;
	logic   cfg_clear;
	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	entry_t q_data;
	entry_t q_head;

	// configuration registers
	assign cfg_clear = cfg_we && ((cfg_index == REG_COLOR_SPACE) ||
		(cfg_index == REG_TEN_BIT) || (cfg_index == REG_BYTE_REVERSE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_RGB;
			cfg_q.ten_bit      <= 1'b0;
			cfg_q.byte_reverse <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_SPACE: begin
					unique case (cfg_data)
						MODE_YUV422: cfg_q.mode <= MODE_YUV422;
						MODE_YUV444: cfg_q.mode <= MODE_YUV444;
						default:     cfg_q.mode <= MODE_RGB;
					endcase
				end
				REG_TEN_BIT:      cfg_q.ten_bit      <= cfg_data[0];
				REG_BYTE_REVERSE: cfg_q.byte_reverse <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: gearbox
	vdu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_clear  (cfg_clear),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	// queue between front and back
	vdu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: conversion pipeline
	vdu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

	// queue is never overrun
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("queue push while full");

	// back end never takes from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("queue pop while empty");

	// a pushed entry is visible at the next edge
	assert property (@(posedge clk) disable iff (!arst_n) q_push |=> !q_empty)
		else $error("queue empty after push");

endmodule

`default_nettype wire
